>>> rtl/sau_pkg.sv
package sau_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Data path
    localparam int WORD_W    = 32;
    localparam int DIV_STEPS = WORD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Action codes
    localparam logic [2:0] ACT_PUSH = 3'd0;
    localparam logic [2:0] ACT_ADD  = 3'd1;
    localparam logic [2:0] ACT_SUB  = 3'd2;
    localparam logic [2:0] ACT_MUL  = 3'd3;
    localparam logic [2:0] ACT_DIV  = 3'd4;
    localparam logic [2:0] ACT_REM  = 3'd5;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_MUL,
        S_DIV
    } state_t;

    // Stack memory access
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

>>> rtl/sau_stack_mem.sv
module sau_stack_mem
    import sau_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [STACK_DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

>>> rtl/sau_divider.sv
module sau_divider
    import sau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient,
    output logic [WORD_W-1:0] remainder
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] div_reg;
    logic              neg_q_reg;
    logic              neg_r_reg;

    logic [WORD_W-1:0] mag_s;
    logic [WORD_W-1:0] mag_t;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;

    // Operand magnitudes; the most negative word maps onto itself unsigned
    assign mag_s = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
    assign mag_t = divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;

    // One restoring step per cycle; the partial remainder stays below the divisor
    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, div_reg};

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Data path
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            quo_reg   <= mag_s;
            div_reg   <= mag_t;
            neg_q_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
            neg_r_reg <= dividend[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W])
            begin
                rem_reg <= diff[WORD_W-1:0];
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[WORD_W-1:0];
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    // Sign fix: quotient truncates toward zero, remainder follows dividend
    assign done      = done_reg;
    assign quotient  = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;

endmodule

>>> rtl/stack_arith_unit.sv
// Push, unknown action and every error beat: result strobed the cycle after start.
// Add and subtract: stack read, then write back; multiply: stack read, product, write back.
// Divide and remainder: stack read, then the 32-step radix-2 divider, then write back.
// busy stays high until the result is strobed; done cannot be stalled.
// Reset (async, active low) empties the stack; stack words are not cleared.
module stack_arith_unit
    import sau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         action,
    input  logic signed [31:0] push_value,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] top_value,
    output logic [6:0]         stack_depth
);

    state_t            state_reg,  state_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [WORD_W-1:0] top_reg,    top_next;
    status_t           status_reg, status_next;
    logic              done_reg,   done_next;
    logic [2:0]        act_reg,    act_next;
    logic [WORD_W-1:0] prod_reg,   prod_next;

    mem_req_t          mem_req;
    logic [WORD_W-1:0] rd_data;
    logic              div_start;
    logic              div_done;
    logic [WORD_W-1:0] div_quo;
    logic [WORD_W-1:0] div_rem;

    logic              fin_en;
    logic [WORD_W-1:0] fin_val;
    logic [ADDR_W-1:0] second_addr;

    assign busy        = (state_reg != S_IDLE);
    assign second_addr = ADDR_W'(count_reg - CNT_W'(2));

    sau_stack_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rd_data)
    );

    sau_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rd_data),
        .divisor   (top_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            top_reg    <= '0;
            status_reg <= ST_OK;
            done_reg   <= 1'b0;
            act_reg    <= ACT_PUSH;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            status_reg <= status_next;
            done_reg   <= done_next;
            act_reg    <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        act_next    = act_reg;
        prod_next   = prod_reg;
        div_start   = 1'b0;
        fin_en      = 1'b0;
        fin_val     = '0;
        mem_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next = action;
                    unique case (action)
                        ACT_PUSH:
                        begin
                            done_next = 1'b1;
                            if (count_reg >= CNT_W'(STACK_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next   = ST_OK;
                                mem_req.we    = 1'b1;
                                mem_req.waddr = ADDR_W'(count_reg);
                                mem_req.wdata = push_value;
                                top_next      = push_value;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_REM:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                done_next   = 1'b1;
                                status_next = ST_SHORT;
                                count_next  = '0;
                                top_next    = '0;
                            end
                            else if ((action == ACT_DIV || action == ACT_REM)
                                     && top_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_DIVZERO;
                                count_next  = '0;
                                top_next    = '0;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = second_addr;
                                state_next    = S_FETCH;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                // rd_data holds the second entry, top_reg the top entry
                unique case (act_reg)
                    ACT_ADD:
                    begin
                        fin_en  = 1'b1;
                        fin_val = rd_data + top_reg;
                    end
                    ACT_SUB:
                    begin
                        fin_en  = 1'b1;
                        fin_val = rd_data - top_reg;
                    end
                    ACT_MUL:
                    begin
                        prod_next  = rd_data * top_reg;
                        state_next = S_MUL;
                    end
                    ACT_DIV, ACT_REM:
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MUL:
            begin
                fin_en  = 1'b1;
                fin_val = prod_reg;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    fin_en  = 1'b1;
                    fin_val = (act_reg == ACT_DIV) ? div_quo : div_rem;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Write back the result over the second entry and pop
        if (fin_en)
        begin
            mem_req.we    = 1'b1;
            mem_req.waddr = second_addr;
            mem_req.wdata = fin_val;
            top_next      = fin_val;
            count_next    = count_reg - 1'b1;
            status_next   = ST_OK;
            done_next     = 1'b1;
            state_next    = S_IDLE;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign top_value   = $signed(top_reg);
    assign stack_depth = 7'(count_reg);

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_fetch_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> $past(state_reg == S_IDLE))
        else $error("fetch not entered from idle");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re))
        else $error("stack read and write in the same cycle");

    a_error_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_SHORT || status_reg == ST_DIVZERO))
        |-> (count_reg == '0 && top_reg == '0))
        else $error("error beat left entries on the stack");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sau_pkg::*;

    // Unassigned action codes: the unit must leave the stack alone
    localparam logic [2:0] ACT_RSVD_A = 3'd6;
    localparam logic [2:0] ACT_RSVD_B = 3'd7;

    // Two shadow stacks: one follows accepted beats, one follows the planned stream
    localparam bit MODEL_CHECK = 1'b0;
    localparam bit MODEL_PLAN  = 1'b1;

    localparam int ITEM_TARGET  = 700;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [2:0]  act;
        logic [31:0] value;
        logic        drain_first;
        logic        allow_gap;
    } beat_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] top;
        logic [6:0]  depth;
    } stack_result_t;

    logic               clk;
    logic               rst_n;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         action = ACT_PUSH;
    logic signed [31:0] push_value = '0;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic [6:0]         stack_depth;

    logic [31:0]   stack_mem [2][STACK_DEPTH];
    int unsigned   stack_fill [2] = '{0, 0};

    beat_t         beat_q[$];
    stack_result_t predicted_results[$];

    int  beats_planned = 0;
    int  beats_sent    = 0;
    int  beats_in      = 0;
    int  gap_left      = 0;
    int  idle_cycles   = 0;
    int  mismatches    = 0;
    bit  gaps_allowed  = 1'b1;
    bit  drain_next    = 1'b0;

    stack_arith_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .push_value  (push_value),
        .done        (done),
        .status      (status),
        .top_value   (top_value),
        .stack_depth (stack_depth)
    );

    // Apply one action to a shadow stack and return the result it should strobe
    function automatic stack_result_t stack_apply(input bit which, input logic [2:0] act,
                                                  input logic [31:0] val);
        logic [31:0]   s;
        logic [31:0]   t;
        logic [31:0]   ms;
        logic [31:0]   mt;
        logic [31:0]   m;
        logic [31:0]   r;
        int unsigned   n;
        status_t       st;
        stack_result_t res;
        n  = stack_fill[which];
        st = ST_OK;
        if (act == ACT_PUSH)
        begin
            if (n >= STACK_DEPTH)
                st = ST_FULL;
            else
            begin
                stack_mem[which][ADDR_W'(n)] = val;
                n++;
            end
        end
        else if (act <= ACT_REM)
        begin
            if (n < 2)
            begin
                n  = 0;
                st = ST_SHORT;
            end
            else
            begin
                t = stack_mem[which][ADDR_W'(n - 1)];
                s = stack_mem[which][ADDR_W'(n - 2)];
                if ((act == ACT_DIV || act == ACT_REM) && t == '0)
                begin
                    n  = 0;
                    st = ST_DIVZERO;
                end
                else
                begin
                    // divide on magnitudes, then fix the sign; min / -1 wraps to min
                    ms = s[31] ? -s : s;
                    mt = t[31] ? -t : t;
                    case (act)
                        ACT_ADD: r = s + t;
                        ACT_SUB: r = s - t;
                        ACT_MUL: r = s * t;
                        ACT_DIV:
                        begin
                            m = ms / mt;
                            r = (s[31] ^ t[31]) ? -m : m;
                        end
                        default:
                        begin
                            m = ms % mt;
                            r = s[31] ? -m : m;
                        end
                    endcase
                    n--;
                    stack_mem[which][ADDR_W'(n - 1)] = r;
                end
            end
        end
        stack_fill[which] = n;
        res.status = st;
        res.top    = (n > 0) ? stack_mem[which][ADDR_W'(n - 1)] : '0;
        res.depth  = n[6:0];
        return res;
    endfunction

    // Append a beat to the stimulus stream and track the stack it builds
    function automatic void queue_beat(input logic [2:0] act, input logic [31:0] value);
        beat_t b;
        b.act         = act;
        b.value       = value;
        b.drain_first = drain_next;
        b.allow_gap   = gaps_allowed;
        drain_next    = 1'b0;
        beat_q.push_back(b);
        void'(stack_apply(MODEL_PLAN, act, value));
        beats_planned++;
    endfunction

    // Operand mix: corner words often, full random otherwise
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return $urandom_range(0, 32) - 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] random_op();
        return 3'($urandom_range(ACT_ADD, ACT_REM));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Driver: holds start until the beat is taken, then idles or launches the next one
    always @(negedge clk)
    begin : drive
        beat_t b;
        logic  next_start;
        next_start = 1'b0;
        if (!rst_n)
            next_start = 1'b0;
        else if (start && beats_in != beats_sent)
            next_start = 1'b1;
        else if (gap_left > 0)
            gap_left--;
        else if (beat_q.size() != 0 &&
                 (!beat_q[0].drain_first || predicted_results.size() == 0))
        begin
            b = beat_q.pop_front();
            next_start = 1'b1;
            action     <= b.act;
            push_value <= b.value;
            beats_sent++;
            if (b.allow_gap && $urandom_range(0, 3) == 0)
                gap_left = $urandom_range(1, 3);
        end
        // junk on the payload while start is low
        if (!next_start)
        begin
            action     <= 3'($urandom);
            push_value <= $urandom;
        end
        start <= next_start;
    end

    // Monitor: check strobed results, predict for each accepted beat
    always @(posedge clk)
    begin : observe
        stack_result_t exp_r;
        logic          active;
        active = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                active = 1'b1;
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d top %0d depth %0d",
                                 status, top_value, stack_depth);
                end
                else
                begin
                    exp_r = predicted_results.pop_front();
                    if (status !== exp_r.status || top_value !== exp_r.top ||
                        stack_depth !== exp_r.depth)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected status %0d top %0d depth %0d,",
                                     exp_r.status, $signed(exp_r.top), exp_r.depth,
                                     " got status %0d top %0d depth %0d",
                                     status, top_value, stack_depth);
                    end
                end
            end
            if (start && !busy)
            begin
                active = 1'b1;
                predicted_results.push_back(stack_apply(MODEL_CHECK, action, push_value));
                beats_in++;
            end
        end
        idle_cycles = active ? 0 : idle_cycles + 1;
    end

    // Watchdog: too long without any beat in or result out
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("FAIL stack_arith_unit");
        $finish;
    end

    initial
    begin
        int         mode;
        int         len;
        int unsigned target;
        rst_n = 1'b0;

        // Directed: errors on an empty and a one-entry stack
        queue_beat(ACT_ADD, $urandom);
        queue_beat(ACT_PUSH, 32'h7FFF_FFFF);
        queue_beat(ACT_SUB, $urandom);
        // max + 1 wraps to the most negative word, then min / -1 and min % -1
        queue_beat(ACT_PUSH, 32'h7FFF_FFFF);
        queue_beat(ACT_PUSH, 32'h0000_0001);
        queue_beat(ACT_ADD, $urandom);
        queue_beat(ACT_PUSH, 32'hFFFF_FFFF);
        queue_beat(ACT_DIV, $urandom);
        queue_beat(ACT_PUSH, 32'hFFFF_FFFF);
        queue_beat(ACT_REM, $urandom);
        // zero divisor on both divide and remainder
        queue_beat(ACT_PUSH, 32'h0000_0000);
        queue_beat(ACT_DIV, $urandom);
        queue_beat(ACT_PUSH, 32'h0000_0007);
        queue_beat(ACT_PUSH, 32'h0000_0000);
        queue_beat(ACT_REM, $urandom);
        // negative dividend: truncation toward zero, remainder takes its sign
        queue_beat(ACT_PUSH, 32'hFFFF_FFF9);
        queue_beat(ACT_PUSH, 32'h0000_0002);
        queue_beat(ACT_DIV, $urandom);
        queue_beat(ACT_PUSH, 32'h0000_0002);
        queue_beat(ACT_REM, $urandom);
        queue_beat(ACT_PUSH, 32'h8000_0000);
        queue_beat(ACT_MUL, $urandom);
        // unassigned actions leave the stack as is
        queue_beat(ACT_RSVD_A, $urandom);
        queue_beat(ACT_RSVD_B, $urandom);
        queue_beat(ACT_SUB, $urandom);

        // Fill to the brim and push past it, after the unit has drained
        drain_next = 1'b1;
        while (stack_fill[MODEL_PLAN] < STACK_DEPTH)
            queue_beat(ACT_PUSH, pick_word());
        repeat (2) queue_beat(ACT_PUSH, pick_word());
        repeat (8) queue_beat(random_op(), $urandom);

        // Random sequences, mostly well formed
        drain_next = 1'b1;
        while (beats_planned < ITEM_TARGET)
        begin
            if (beats_planned > ITEM_TARGET - 100)
                gaps_allowed = 1'b0;
            if ($urandom_range(0, 11) == 0)
                drain_next = 1'b1;
            mode = $urandom_range(0, 99);
            if (mode < 55)
            begin
                len = $urandom_range(4, 20);
                repeat (len)
                begin
                    if (stack_fill[MODEL_PLAN] < 2 ||
                        (stack_fill[MODEL_PLAN] < STACK_DEPTH && $urandom_range(0, 9) < 4))
                        queue_beat(ACT_PUSH, pick_word());
                    else
                        queue_beat(random_op(), $urandom);
                end
            end
            else if (mode < 70)
            begin
                // deep stack, sometimes full with pushes beyond
                target = ($urandom_range(0, 2) == 0) ? STACK_DEPTH
                                                     : $urandom_range(40, STACK_DEPTH - 1);
                while (stack_fill[MODEL_PLAN] < target)
                    queue_beat(ACT_PUSH, pick_word());
                if (target == STACK_DEPTH)
                    repeat ($urandom_range(1, 3)) queue_beat(ACT_PUSH, pick_word());
                repeat ($urandom_range(5, 60)) queue_beat(random_op(), $urandom);
            end
            else if (mode < 88)
            begin
                // noise: any action code
                repeat ($urandom_range(1, 8))
                    queue_beat(3'($urandom_range(0, 7)), $urandom);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                // zero divisor after a valid push
                queue_beat(ACT_PUSH, pick_word());
                queue_beat(ACT_PUSH, 32'h0000_0000);
                queue_beat(($urandom_range(0, 1) != 0) ? ACT_DIV : ACT_REM, $urandom);
            end
            else
            begin
                // reduce until too short, then one more operation
                while (stack_fill[MODEL_PLAN] >= 2)
                    queue_beat(random_op(), $urandom);
                queue_beat(random_op(), $urandom);
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every beat to go in and every result to come back
        while (beat_q.size() != 0 || beats_in != beats_sent || predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (predicted_results.size() != 0)
        begin
            mismatches += predicted_results.size();
            $display("%0d results never strobed", predicted_results.size());
        end
        if (mismatches == 0)
            $display("PASS stack_arith_unit");
        else
            $display("FAIL stack_arith_unit");
        $finish;
    end

endmodule

>>> files.f
rtl/sau_pkg.sv
rtl/sau_stack_mem.sv
rtl/sau_divider.sv
rtl/stack_arith_unit.sv
sim/testbench.sv
